// ===== hw/rtl/fmprc_pkg.sv =====
// shared types and constants of the first-match packet rule classifier
package fmprc_pkg;

    // stream widths
    localparam int DATA_IN_W  = 216;
    localparam int USER_IN_W  = 2;
    localparam int DATA_OUT_W = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    // operation codes on the input tuser
    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_APPEND   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    // decoded command kind
    typedef enum logic [1:0] {
        KIND_CLASSIFY = 2'd0,
        KIND_APPEND   = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_NOP      = 2'd3
    } t_kind;

    // one decoded item as it travels through the queue
    typedef struct packed {
        t_kind       kind;
        logic        action;
        logic [1:0]  direction;
        logic [7:0]  protocol;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [6:0]  wildcard_mask;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // result item, verdict in the lowest bit
    typedef struct packed {
        logic       table_full;
        logic [4:0] matched_index;
        logic       matched;
        logic       verdict;
    } t_result;

endpackage

// ===== hw/rtl/fmprc_front.sv =====
// front stage: takes input items, decodes the operation and feeds the command queue
module fmprc_front
    import fmprc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_IN_W-1:0] i_s_tdata,
    input  logic [USER_IN_W-1:0] i_s_tuser,
    input  t_q_stat              i_q_stat,
    output logic                 o_q_push,
    output t_cmd                 o_q_cmd
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    // operation decode and field unpacking
    always_comb begin
        unique case (i_s_tuser)
            OP_CLASSIFY: n_cmd.kind = KIND_CLASSIFY;
            OP_APPEND:   n_cmd.kind = KIND_APPEND;
            OP_CLEAR:    n_cmd.kind = KIND_CLEAR;
            default:     n_cmd.kind = KIND_NOP;
        endcase
        n_cmd.action        = i_s_tdata[0];
        n_cmd.direction     = i_s_tdata[2:1];
        n_cmd.protocol      = i_s_tdata[10:3];
        n_cmd.src_mac       = i_s_tdata[58:11];
        n_cmd.dst_mac       = i_s_tdata[106:59];
        n_cmd.src_ip        = i_s_tdata[138:107];
        n_cmd.dst_ip        = i_s_tdata[170:139];
        n_cmd.src_port      = i_s_tdata[186:171];
        n_cmd.dst_port      = i_s_tdata[202:187];
        n_cmd.wildcard_mask = i_s_tdata[209:203];
    end

    // handshake: hold one item until the queue takes it
    assign o_q_push   = r_valid && !i_q_stat.full;
    assign o_s_tready = !r_valid || o_q_push;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_q_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    // decoded payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/fmprc_cmd_queue.sv =====
// short command queue between the front stage and the rule engine
module fmprc_cmd_queue
    import fmprc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/fmprc_engine.sv =====
// rule engine: rule memory, sequential first-match scan and result register
module fmprc_engine
    import fmprc_pkg::*;
#(
    parameter int MAX_RULES = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_q_cmd,
    input  t_q_stat i_q_stat,
    output logic    o_q_pop,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_result o_m_tdata
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam logic [1:0] DIR_ANY = 2'd2;

    // one stored rule
    typedef struct packed {
        logic        action;
        logic [1:0]  direction;
        logic [7:0]  protocol;
        logic [6:0]  wildcard_mask;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_rule;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    // does a stored rule match the packet
    function automatic logic rule_hit(input t_rule r, input t_cmd p);
        logic ok;
        ok = (r.direction == DIR_ANY) || (r.direction == p.direction);
        ok = ok && (r.wildcard_mask[0] || r.protocol == p.protocol);
        ok = ok && (r.wildcard_mask[1] || r.src_mac  == p.src_mac);
        ok = ok && (r.wildcard_mask[2] || r.dst_mac  == p.dst_mac);
        ok = ok && (r.wildcard_mask[3] || r.src_ip   == p.src_ip);
        ok = ok && (r.wildcard_mask[4] || r.dst_ip   == p.dst_ip);
        ok = ok && (r.wildcard_mask[5] || r.src_port == p.src_port);
        ok = ok && (r.wildcard_mask[6] || r.dst_port == p.dst_port);
        return ok;
    endfunction

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_iss_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    t_rule            r_rd_q;
    t_cmd             r_pkt;
    t_result          r_res;
    logic             r_o_valid;
    t_result          r_o_data;

    t_rule            r_mem [MAX_RULES];

    logic             slot_free;
    logic             is_classify;
    logic             tbl_full;
    logic             hit;
    logic             more;
    logic             wr_en;
    logic             rd_en;
    t_rule            wr_rule;
    logic             res_load;
    t_result          res_data;
    t_result          hit_res;
    logic [31:0]      idx_wide;

    assign slot_free   = !r_o_valid || i_m_tready;
    assign is_classify = (i_q_cmd.kind == KIND_CLASSIFY);
    assign tbl_full    = (r_count >= CNT_W'(MAX_RULES));
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_stat.empty && (is_classify || slot_free);
    assign hit         = r_rd_vld && rule_hit(r_rd_q, r_pkt);
    assign more        = (r_iss_idx < r_count);
    assign wr_en       = o_q_pop && (i_q_cmd.kind == KIND_APPEND) && !tbl_full;
    assign rd_en       = (r_state == S_SCAN) && !hit && more;
    assign idx_wide    = 32'(r_rd_idx);

    // rule image of the queued command
    always_comb begin
        wr_rule.action        = i_q_cmd.action;
        wr_rule.direction     = i_q_cmd.direction;
        wr_rule.protocol      = i_q_cmd.protocol;
        wr_rule.wildcard_mask = i_q_cmd.wildcard_mask;
        wr_rule.src_mac       = i_q_cmd.src_mac;
        wr_rule.dst_mac       = i_q_cmd.dst_mac;
        wr_rule.src_ip        = i_q_cmd.src_ip;
        wr_rule.dst_ip        = i_q_cmd.dst_ip;
        wr_rule.src_port      = i_q_cmd.src_port;
        wr_rule.dst_port      = i_q_cmd.dst_port;
    end

    // result of a hit
    always_comb begin
        hit_res               = '0;
        hit_res.verdict       = r_rd_q.action;
        hit_res.matched       = 1'b1;
        hit_res.matched_index = idx_wide[4:0];
    end

    // result register load
    always_comb begin
        res_load = 1'b0;
        res_data = '0;
        if (o_q_pop && !is_classify) begin
            res_load = 1'b1;
            res_data.table_full = (i_q_cmd.kind == KIND_APPEND) && tbl_full;
        end else if ((r_state == S_RESULT) && slot_free) begin
            res_load = 1'b1;
            res_data = r_res;
        end
    end

    // sequencer and table count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (o_q_pop) begin
                        unique case (i_q_cmd.kind)
                            KIND_CLASSIFY: r_state <= S_SCAN;
                            KIND_APPEND: begin
                                if (!tbl_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            KIND_CLEAR:    r_count <= '0;
                            default:       r_count <= r_count;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_rd_vld <= 1'b0;
                        r_state  <= S_RESULT;
                    end else if (more) begin
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_RESULT: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // scan payload: packet, issue index, pending result
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pkt     <= i_q_cmd;
            r_iss_idx <= '0;
            r_res     <= '0;
        end
        if (rd_en) begin
            r_iss_idx <= r_iss_idx + 1'b1;
            r_rd_idx  <= r_iss_idx;
        end
        if ((r_state == S_SCAN) && hit) begin
            r_res <= hit_res;
        end
    end

    // rule memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= wr_rule;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[r_iss_idx[IDX_W-1:0]];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o_data <= res_data;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule

// ===== hw/rtl/first_match_packet_rule_classifier.sv =====
// top level of the first-match packet rule classifier
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: rule and packet fields, tuser: operation
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: verdict, matched, index, table_full
//
// an item passes the front register and then the command queue
// append, clear and unknown operations are answered from the idle state; a classify
// scans the stored rules in order, comparing one stored rule per cycle
// reset clears control state only; stored rules are never read past the rule count
// the front keeps taking items while the engine scans or the result waits, until the
// command queue is full; the engine stalls when the output register is held
module first_match_packet_rule_classifier
    import fmprc_pkg::*;
#(
    parameter int MAX_RULES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bits from 0: rule_action, direction[2], protocol[8], src_mac[48], dst_mac[48],
    // src_ip[32], dst_ip[32], src_port[16], dst_port[16], wildcard_mask[7], zero fill
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,
    // bits from 0: operation[2]
    input  logic [USER_IN_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // bits from 0: verdict, matched, matched_index[5], table_full
    output logic [DATA_OUT_W-1:0] m_axis_tdata
);

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    t_result res;

    // front: accept and decode
    fmprc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_stat   (q_stat),
        .o_q_push   (q_push),
        .o_q_cmd    (front_cmd)
    );

    // decoupling queue
    fmprc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // back: rule table and scan
    fmprc_engine #(
        .MAX_RULES (MAX_RULES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_cmd    (q_cmd),
        .i_q_stat   (q_stat),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (res)
    );

    assign m_axis_tdata = res;

    // checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("engine popped an empty queue");

    a_full_not_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(res.table_full && res.matched))
        else $error("result flags both table full and a match");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !res.matched) |-> (res.verdict == 1'b0 && res.matched_index == 5'd0))
        else $error("result without a match carries a verdict or index");

endmodule

// ===== test/tb_first_match_packet_rule_classifier.sv =====
// self-checking testbench for the first-match packet rule classifier
module tb_first_match_packet_rule_classifier
    import fmprc_pkg::*;
();

    localparam int TABLE_DEPTH  = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1680;
    localparam int CALM_ITEMS   = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 64;

    // operation code with no defined effect
    localparam logic [1:0] OP_NONE = 2'd3;

    // direction codes
    localparam logic [1:0] DIR_IN       = 2'd0;
    localparam logic [1:0] DIR_OUT      = 2'd1;
    localparam logic [1:0] DIR_ANY      = 2'd2;
    localparam logic [1:0] DIR_RESERVED = 2'd3;

    // rule actions
    localparam logic ACT_ACCEPT = 1'b0;
    localparam logic ACT_DROP   = 1'b1;

    // wildcard bit positions
    localparam int WC_PROTO = 0;
    localparam int WC_SMAC  = 1;
    localparam int WC_DMAC  = 2;
    localparam int WC_SIP   = 3;
    localparam int WC_DIP   = 4;
    localparam int WC_SPORT = 5;
    localparam int WC_DPORT = 6;

    // one input item, also the layout of a stored rule
    typedef struct packed {
        logic [1:0]  op;
        logic        action;
        logic [1:0]  dir;
        logic [7:0]  proto;
        logic [47:0] smac;
        logic [47:0] dmac;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [6:0]  wild;
    } t_rule_item;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata;
    logic [USER_IN_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_OUT_W-1:0] m_axis_tdata;

    // shadow copy of the rule table
    t_rule_item  shadow_rules [TABLE_DEPTH];
    int          shadow_count;
    t_result     expected_verdicts [$];

    int          error_count;
    int          cycle_count;
    int          hold_left;
    bit          idle_on;

    first_match_packet_rule_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // rule match: direction, then each field unless wildcarded
    function automatic bit rule_matches(input t_rule_item r, input t_rule_item p);
        if (r.dir != DIR_ANY && r.dir != p.dir) return 1'b0;
        if (!r.wild[WC_PROTO] && r.proto != p.proto) return 1'b0;
        if (!r.wild[WC_SMAC]  && r.smac  != p.smac)  return 1'b0;
        if (!r.wild[WC_DMAC]  && r.dmac  != p.dmac)  return 1'b0;
        if (!r.wild[WC_SIP]   && r.sip   != p.sip)   return 1'b0;
        if (!r.wild[WC_DIP]   && r.dip   != p.dip)   return 1'b0;
        if (!r.wild[WC_SPORT] && r.sport != p.sport) return 1'b0;
        if (!r.wild[WC_DPORT] && r.dport != p.dport) return 1'b0;
        return 1'b1;
    endfunction

    // expected verdict of one item, updating the shadow table
    function automatic t_result classify_and_update(input t_rule_item it);
        t_result res;
        res = '0;
        case (it.op)
            OP_CLASSIFY: begin
                for (int idx = 0; idx < shadow_count; idx++) begin
                    if (rule_matches(shadow_rules[idx], it)) begin
                        res.verdict       = shadow_rules[idx].action;
                        res.matched       = 1'b1;
                        res.matched_index = 5'(idx);
                        break;
                    end
                end
            end
            OP_APPEND: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    res.table_full = 1'b1;
                end else begin
                    shadow_rules[shadow_count] = it;
                    shadow_count++;
                end
            end
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_rule_item random_item(input logic [1:0] op);
        t_rule_item it;
        it.op     = op;
        it.action = 1'($urandom_range(1));
        it.dir    = 2'($urandom_range(3));
        it.proto  = 8'($urandom_range(255));
        it.smac   = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
        it.dmac   = {16'($urandom_range(16'hFFFF)), 32'($urandom)};
        it.sip    = $urandom;
        it.dip    = $urandom;
        it.sport  = 16'($urandom_range(16'hFFFF));
        it.dport  = 16'($urandom_range(16'hFFFF));
        it.wild   = 7'($urandom_range(127));
        return it;
    endfunction

    // flip one bit of one field; index 7 changes the direction instead
    function automatic t_rule_item perturb_field(input t_rule_item p, input int field);
        case (field)
            0: p.proto ^= 8'(1)  << $urandom_range(7);
            1: p.smac  ^= 48'(1) << $urandom_range(47);
            2: p.dmac  ^= 48'(1) << $urandom_range(47);
            3: p.sip   ^= 32'(1) << $urandom_range(31);
            4: p.dip   ^= 32'(1) << $urandom_range(31);
            5: p.sport ^= 16'(1) << $urandom_range(15);
            6: p.dport ^= 16'(1) << $urandom_range(15);
            default: p.dir ^= 2'($urandom_range(1, 3));
        endcase
        return p;
    endfunction

    // packet built to hit a stored rule, sometimes nudged off it
    function automatic t_rule_item packet_from_rule();
        t_rule_item p;
        t_rule_item r;
        p = random_item(OP_CLASSIFY);
        r = shadow_rules[$urandom_range(shadow_count - 1)];
        p.dir = (r.dir == DIR_ANY) ? 2'($urandom_range(3)) : r.dir;
        if (!r.wild[WC_PROTO]) p.proto = r.proto;
        if (!r.wild[WC_SMAC])  p.smac  = r.smac;
        if (!r.wild[WC_DMAC])  p.dmac  = r.dmac;
        if (!r.wild[WC_SIP])   p.sip   = r.sip;
        if (!r.wild[WC_DIP])   p.dip   = r.dip;
        if (!r.wild[WC_SPORT]) p.sport = r.sport;
        if (!r.wild[WC_DPORT]) p.dport = r.dport;
        if ($urandom_range(99) < 30) p = perturb_field(p, $urandom_range(7));
        return p;
    endfunction

    // rule to append: fresh, or a variant of a stored one to build shadowing
    function automatic t_rule_item random_rule();
        t_rule_item r;
        int pick;
        r = random_item(OP_APPEND);
        if (shadow_count > 0 && $urandom_range(1) == 1) begin
            r        = shadow_rules[$urandom_range(shadow_count - 1)];
            r.op     = OP_APPEND;
            r.action = 1'($urandom_range(1));
            if ($urandom_range(3) == 0) r.dir = 2'($urandom_range(3));
        end
        pick = $urandom_range(99);
        if (pick < 30)
            r.wild = '0;
        else if (pick < 40)
            r.wild = '1;
        else
            r.wild = 7'($urandom_range(127));
        return r;
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_item(input t_rule_item it);
        // idle cycles before the offer, each with the same chance
        if (idle_on) begin
            while ($urandom_range(99) < 29) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_IN_W'({it.wild, it.dport, it.sport, it.dip, it.sip,
                                     it.dmac, it.smac, it.proto, it.dir, it.action});
        s_axis_tuser  <= it.op;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        expected_verdicts.insert(expected_verdicts.size(), classify_and_update(it));
    endtask

    // stop offering and let every expected result arrive
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // receiver: long hold-off when asked, random stalls while idle_on, else always ready
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 29);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = t_result'(m_axis_tdata);
            if (expected_verdicts.size() == 0) begin
                report_error($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                if (got.verdict !== want.verdict)
                    report_error($sformatf("verdict %b, expected %b",
                                           got.verdict, want.verdict));
                if (got.matched !== want.matched)
                    report_error($sformatf("matched %b, expected %b",
                                           got.matched, want.matched));
                if (got.matched_index !== want.matched_index)
                    report_error($sformatf("matched_index %0d, expected %0d",
                                           got.matched_index, want.matched_index));
                if (got.table_full !== want.table_full)
                    report_error($sformatf("table_full %b, expected %b",
                                           got.table_full, want.table_full));
            end
        end
    end

    // directed: empty table, unknown operation, exact and near hits, odd directions
    task automatic test_directed();
        t_rule_item a;
        t_rule_item p;
        a        = '1;
        a.op     = OP_APPEND;
        a.action = ACT_DROP;
        a.dir    = DIR_IN;
        a.wild   = '0;

        p     = a;
        p.op  = OP_CLASSIFY;
        p.dir = DIR_RESERVED;
        send_item(p);
        p.op = OP_NONE;
        send_item(p);

        send_item(a);
        p     = a;
        p.op  = OP_CLASSIFY;
        send_item(p);
        p.dir = DIR_OUT;
        send_item(p);
        // one field off at a time
        for (int f = 0; f < 7; f++) begin
            p    = a;
            p.op = OP_CLASSIFY;
            send_item(perturb_field(p, f));
        end

        // reserved direction rule over all-zero fields
        p        = '0;
        p.op     = OP_APPEND;
        p.action = ACT_DROP;
        p.dir    = DIR_RESERVED;
        send_item(p);
        p.op = OP_CLASSIFY;
        send_item(p);
        p.dir = DIR_ANY;
        send_item(p);

        // catch-all rule, accepting
        p        = '0;
        p.op     = OP_APPEND;
        p.action = ACT_ACCEPT;
        p.dir    = DIR_ANY;
        p.wild   = '1;
        send_item(p);
        p.op = OP_CLASSIFY;
        send_item(p);

        // first match still wins
        p    = a;
        p.op = OP_CLASSIFY;
        send_item(p);

        p.op = OP_CLEAR;
        send_item(p);
        p.op = OP_CLASSIFY;
        send_item(p);
        drain_results();
    endtask

    // fill the table and append past its end
    task automatic test_table_full();
        t_rule_item it;
        it    = random_item(OP_CLEAR);
        send_item(it);
        for (int n = 0; n < TABLE_DEPTH + 2; n++) send_item(random_rule());
        send_item(packet_from_rule());
        send_item(random_item(OP_CLASSIFY));
        it = random_item(OP_CLEAR);
        send_item(it);
        send_item(random_item(OP_APPEND));
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_left <= HOLD_CYCLES;
        for (int n = 0; n < 16; n++) begin
            if (n % 3 == 0 || shadow_count == 0)
                send_item(random_rule());
            else
                send_item(packet_from_rule());
        end
        drain_results();
    endtask

    // random mix, mostly packets, most of them aimed at stored rules
    task automatic test_random();
        int pick;
        idle_on = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_ITEMS) idle_on = 1'b1;
            pick = $urandom_range(99);
            if (pick < 60) begin
                if (shadow_count > 0 && $urandom_range(99) < 75)
                    send_item(packet_from_rule());
                else
                    send_item(random_item(OP_CLASSIFY));
            end else if (pick < 95) begin
                send_item(random_rule());
            end else if (pick < 97) begin
                send_item(random_item(OP_CLEAR));
            end else begin
                send_item(random_item(OP_NONE));
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        shadow_count  = 0;
        error_count   = 0;
        cycle_count   = 0;
        hold_left     = 0;
        idle_on       = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random();

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fmprc_pkg.sv
hw/rtl/fmprc_front.sv
hw/rtl/fmprc_cmd_queue.sv
hw/rtl/fmprc_engine.sv
hw/rtl/first_match_packet_rule_classifier.sv
test/tb_first_match_packet_rule_classifier.sv
